/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker module of the grid map block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GMNT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GMNT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/gmnt_pkg.sv */
// Shared types, codes and constants of the grid map nearest target search block.
`timescale 1ns / 1ps
`default_nettype none

package gmnt_pkg;

    // Default grid capacity
    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 32;

    // Field widths
    localparam int CMD_W      = 3;
    localparam int POS_X_W    = 6;
    localparam int POS_Y_W    = 5;
    localparam int CELL_W     = 2;
    localparam int COST_W     = 16;
    localparam int MASK_W     = 4;
    localparam int DIST_W     = 7;
    localparam int COLS_REG_W = 7;
    localparam int ROWS_REG_W = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLS_REG_W;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd1;
    localparam logic [COLS_REG_W-1:0] COLS_RESET = 7'd64;
    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 6'd32;

    // Neighbour step cost and saturation limit
    localparam logic [COST_W-1:0] STEP_COST = 16'd5;
    localparam logic [COST_W-1:0] COST_MAX  = 16'hFFFF;

    // Cell types
    localparam logic [CELL_W-1:0] CELL_OPEN   = 2'd0;
    localparam logic [CELL_W-1:0] CELL_WALL   = 2'd1;
    localparam logic [CELL_W-1:0] CELL_HOME   = 2'd2;
    localparam logic [CELL_W-1:0] CELL_TARGET = 2'd3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PICKUP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NBR     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEAREST = 3'd4;
    localparam logic [CMD_W-1:0] CMD_HOME    = 3'd5;

    // Input word
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [POS_X_W-1:0] pos_x;
        logic [POS_Y_W-1:0] pos_y;
        logic [CELL_W-1:0]  cell_type_in;
        logic [COST_W-1:0]  path_cost;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [CELL_W-1:0]  cell_type_out;
        logic [MASK_W-1:0]  neighbour_mask;
        logic [COST_W-1:0]  neighbour_cost;
        logic               found;
        logic [POS_X_W-1:0] result_x;
        logic [POS_Y_W-1:0] result_y;
        logic [DIST_W-1:0]  distance;
    } t_out_word;

endpackage

`default_nettype wire

/* rtl/core/gmnt_cell_ram.sv */
// Single-port-write, single-port-read cell memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gmnt_cell_ram
    import gmnt_pkg::*;
#(
    parameter int AW = 11
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [CELL_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [CELL_W-1:0] o_rd_data
);

    localparam int DEPTH = 2 ** AW;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    // Write one cell
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one cell, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/core/grid_map_nearest_target_search.sv */
// Top level of the grid map nearest target search block.
`timescale 1ns / 1ps
`default_nettype none

// Grid of 2-bit cells (open, wall, home, target) held in one on-chip RAM with one
// read port and one write port; a small sequencer drives that read port and one
// distance/compare unit. After reset the block sweeps all RAM cells to open, one
// cell a cycle, 2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) cells (2048 at the defaults),
// and stalls its input meanwhile; configuration writes are taken at any time.
// Write, pickup, read and unused commands probe one cell; the neighbours command
// probes five (centre, then up, left, right, down) through the single RAM port;
// both scans probe every cell of the used area in row-major order, one cell per
// cycle, set by the RAM read port. One word is in flight at a time; the result sits
// in an output register so the next word may be accepted while it waits.
module grid_map_nearest_target_search
    import gmnt_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_data
);

    localparam int SXW = $clog2(MAX_COLS);
    localparam int SYW = $clog2(MAX_ROWS);
    localparam int AW  = SXW + SYW;
    localparam int UCW = (COLS_REG_W > $clog2(MAX_COLS + 1)) ? COLS_REG_W
                                                               : $clog2(MAX_COLS + 1);
    localparam int URW = (ROWS_REG_W > $clog2(MAX_ROWS + 1)) ? ROWS_REG_W
                                                               : $clog2(MAX_ROWS + 1);
    localparam int XW  = (SXW > POS_X_W) ? SXW : POS_X_W;
    localparam int YW  = (SYW > POS_Y_W) ? SYW : POS_Y_W;
    localparam int DW  = ((XW > YW) ? XW : YW) + 1;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_NBR   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Probe kinds
    localparam logic [1:0] PK_CENTER = 2'd0;
    localparam logic [1:0] PK_NBR    = 2'd1;
    localparam logic [1:0] PK_SCAN   = 2'd2;

    // Neighbour order, equal to the mask bit
    localparam logic [1:0] NB_UP    = 2'd0;
    localparam logic [1:0] NB_LEFT  = 2'd1;
    localparam logic [1:0] NB_RIGHT = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    logic [COLS_REG_W-1:0] r_cols;
    logic [ROWS_REG_W-1:0] r_rows;
    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [AW-1:0]         r_clr_addr;
    t_in_word              r_item;
    logic                  r_cin;
    logic [1:0]            r_nb_idx;
    logic [SXW-1:0]        r_sx;
    logic [SYW-1:0]        r_sy;

    // Returning probe tag
    logic                  r_pv;
    logic [1:0]            r_pk;
    logic                  r_pinb;
    logic                  r_plast;
    logic [1:0]            r_pnb;
    logic [SXW-1:0]        r_px;
    logic [SYW-1:0]        r_py;

    // Result accumulators
    logic [CELL_W-1:0]     r_before;
    logic [MASK_W-1:0]     r_mask;
    logic                  r_found;
    logic [SXW-1:0]        r_rx;
    logic [SYW-1:0]        r_ry;
    logic [DW-1:0]         r_dist;

    logic                  r_out_valid;
    t_out_word             r_out_data;

    logic [UCW-1:0]        used_cols;
    logic [URW-1:0]        used_rows;
    logic [SXW-1:0]        w_last;
    logic [SYW-1:0]        h_last;
    logic                  in_acc;
    logic                  in_inside;
    logic                  out_load;

    logic                  iss_en;
    logic [1:0]            iss_kind;
    logic                  iss_inb;
    logic                  iss_last;
    logic [SXW-1:0]        iss_x;
    logic [SYW-1:0]        iss_y;

    logic [UCW-1:0]        nb_x;
    logic [URW-1:0]        nb_y;
    logic                  nb_ok;
    logic                  scan_last;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [CELL_W-1:0]     wr_data;
    logic [CELL_W-1:0]     rd_data;
    logic                  cell_wr;

    logic [XW-1:0]         dx;
    logic [YW-1:0]         dy;
    logic [DW-1:0]         dist_now;
    logic [COST_W:0]       cost_sum;
    logic [COST_W-1:0]     cost_sat;

    // Clamp the configured grid size
    always_comb begin
        if (r_cols == '0) begin
            used_cols = UCW'(1);
        end else if (UCW'(r_cols) > UCW'(MAX_COLS)) begin
            used_cols = UCW'(MAX_COLS);
        end else begin
            used_cols = UCW'(r_cols);
        end
        if (r_rows == '0) begin
            used_rows = URW'(1);
        end else if (URW'(r_rows) > URW'(MAX_ROWS)) begin
            used_rows = URW'(MAX_ROWS);
        end else begin
            used_rows = URW'(r_rows);
        end
    end

    assign w_last = SXW'(used_cols - UCW'(1));
    assign h_last = SYW'(used_rows - URW'(1));

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_inside  = (UCW'(i_in_data.pos_x) < used_cols)
                     && (URW'(i_in_data.pos_y) < used_rows);
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);
    assign scan_last  = (r_sx == w_last) && (r_sy == h_last);

    // Pick the neighbour coordinate for the current step
    always_comb begin
        nb_x  = UCW'(r_item.pos_x);
        nb_y  = URW'(r_item.pos_y);
        nb_ok = 1'b1;
        case (r_nb_idx)
            NB_UP: begin
                nb_y  = URW'(r_item.pos_y) - URW'(1);
                nb_ok = (r_item.pos_y != '0);
            end
            NB_LEFT: begin
                nb_x  = UCW'(r_item.pos_x) - UCW'(1);
                nb_ok = (r_item.pos_x != '0);
            end
            NB_RIGHT: begin
                nb_x = UCW'(r_item.pos_x) + UCW'(1);
            end
            NB_DOWN: begin
                nb_y = URW'(r_item.pos_y) + URW'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // Issue one cell probe a cycle in the neighbour and scan states, one on accept
    always_comb begin
        iss_en   = 1'b0;
        iss_kind = PK_CENTER;
        iss_inb  = 1'b0;
        iss_last = 1'b0;
        iss_x    = '0;
        iss_y    = '0;
        case (r_state)
            ST_IDLE: begin
                iss_en   = in_acc;
                iss_inb  = in_inside;
                iss_last = !(i_in_data.command inside {CMD_NBR, CMD_NEAREST, CMD_HOME});
                iss_x    = SXW'(i_in_data.pos_x);
                iss_y    = SYW'(i_in_data.pos_y);
            end
            ST_NBR: begin
                iss_en   = 1'b1;
                iss_kind = PK_NBR;
                iss_inb  = r_cin && nb_ok && (nb_x < used_cols) && (nb_y < used_rows);
                iss_last = (r_nb_idx == NB_DOWN);
                iss_x    = SXW'(nb_x);
                iss_y    = SYW'(nb_y);
            end
            ST_SCAN: begin
                iss_en   = 1'b1;
                iss_kind = PK_SCAN;
                iss_inb  = 1'b1;
                iss_last = scan_last;
                iss_x    = r_sx;
                iss_y    = r_sy;
            end
            default: begin
                iss_en = 1'b0;
            end
        endcase
    end

    // Next sequencer state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == {AW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.command)
                        CMD_NBR:               n_state = ST_NBR;
                        CMD_NEAREST, CMD_HOME: n_state = ST_SCAN;
                        default:               n_state = ST_DRAIN;
                    endcase
                end
            end
            ST_NBR, ST_SCAN: begin
                if (iss_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_pv && r_plast) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Write or pick up the addressed cell when its old value returns
    assign cell_wr = r_pv && (r_pk == PK_CENTER) && r_pinb
                  && ((r_item.command == CMD_WRITE)
                   || ((r_item.command == CMD_PICKUP) && (rd_data == CELL_TARGET)));

    always_comb begin
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = CELL_OPEN;
        end else begin
            wr_en   = cell_wr;
            wr_addr = {r_py, r_px};
            wr_data = (r_item.command == CMD_WRITE) ? r_item.cell_type_in : CELL_OPEN;
        end
    end

    gmnt_cell_ram #(
        .AW (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (iss_en && iss_inb),
        .i_rd_addr ({iss_y, iss_x}),
        .o_rd_data (rd_data)
    );

    // Manhattan distance of the returning scan cell
    always_comb begin
        dx = (XW'(r_item.pos_x) > XW'(r_px)) ? XW'(r_item.pos_x) - XW'(r_px)
                                            : XW'(r_px) - XW'(r_item.pos_x);
        dy = (YW'(r_item.pos_y) > YW'(r_py)) ? YW'(r_item.pos_y) - YW'(r_py)
                                            : YW'(r_py) - YW'(r_item.pos_y);
        dist_now = DW'(dx) + DW'(dy);
    end

    // Saturating step cost
    assign cost_sum = {1'b0, r_item.path_cost} + {1'b0, STEP_COST};
    assign cost_sat = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= COLS_RESET;
            r_rows      <= ROWS_RESET;
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= iss_en;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_COLS: r_cols <= i_cfg_data;
                    REG_ROWS: r_rows <= i_cfg_data[ROWS_REG_W-1:0];
                    default:  r_cols <= r_cols;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch the word, step the sequencer counters, tag probes
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item   <= i_in_data;
            r_cin    <= in_inside;
            r_nb_idx <= NB_UP;
            r_sx     <= '0;
            r_sy     <= '0;
        end
        if (r_state == ST_NBR) begin
            r_nb_idx <= r_nb_idx + 2'd1;
        end
        if (r_state == ST_SCAN) begin
            if (r_sx == w_last) begin
                r_sx <= '0;
                r_sy <= r_sy + SYW'(1);
            end else begin
                r_sx <= r_sx + SXW'(1);
            end
        end
        if (iss_en) begin
            r_pk    <= iss_kind;
            r_pinb  <= iss_inb;
            r_plast <= iss_last;
            r_pnb   <= r_nb_idx;
            r_px    <= iss_x;
            r_py    <= iss_y;
        end
    end

    // Fold returning cells into the result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mask  <= '0;
            r_found <= 1'b0;
            r_rx    <= '0;
            r_ry    <= '0;
            r_dist  <= '0;
        end else if (r_pv) begin
            case (r_pk)
                PK_CENTER: begin
                    r_before <= r_pinb ? rd_data : CELL_OPEN;
                end
                PK_NBR: begin
                    r_mask[r_pnb] <= r_pinb && (rd_data != CELL_WALL);
                end
                PK_SCAN: begin
                    if (r_item.command == CMD_NEAREST) begin
                        if ((rd_data == CELL_TARGET) && (!r_found || (dist_now < r_dist))) begin
                            r_found <= 1'b1;
                            r_rx    <= r_px;
                            r_ry    <= r_py;
                            r_dist  <= dist_now;
                        end
                    end else if ((rd_data == CELL_HOME) && !r_found) begin
                        r_found <= 1'b1;
                        r_rx    <= r_px;
                        r_ry    <= r_py;
                    end
                end
                default: begin
                    r_before <= r_before;
                end
            endcase
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.cell_type_out  <= r_before;
            r_out_data.neighbour_mask <= r_mask;
            r_out_data.neighbour_cost <= (r_item.command == CMD_NBR) ? cost_sat : '0;
            r_out_data.found          <= r_found;
            r_out_data.result_x       <= POS_X_W'(r_rx);
            r_out_data.result_y       <= POS_Y_W'(r_ry);
            r_out_data.distance       <= DIST_W'(r_dist);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* rtl/core/gmnt_checker.sv */
// Port-level checker of the grid map nearest target search block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gmnt_checker
    import gmnt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // Hold a stalled result word
    `GMNT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result word changed")

    // Stall the input while a word is at work
    `GMNT_ASSERT_NXT(a_busy_stall, i_clk, i_rst_n, in_acc, o_in_stall, "input not stalled after accept")

    // Zero the location when nothing was found
    `GMNT_ASSERT_IMP(a_none_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.found, (o_out_data.result_x == '0) && (o_out_data.result_y == '0) && (o_out_data.distance == '0), "location set without a find")

    // Keep neighbour and scan fields apart
    `GMNT_ASSERT_IMP(a_mask_excl, i_clk, i_rst_n, o_out_valid && (o_out_data.neighbour_mask != '0), !o_out_data.found && (o_out_data.distance == '0), "neighbour mask with scan result")

endmodule

bind grid_map_nearest_target_search gmnt_checker u_gmnt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

/* tb/sv/gmnt_result_checker.sv */
// Checker for the grid map block: tracks the grid, predicts each result word and compares.
`timescale 1ns / 1ps

module gmnt_result_checker
    import gmnt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_word              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_word             i_out_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the grid and the area registers
    logic [CELL_W-1:0]     cell_grid [MAX_ROWS_DEF][MAX_COLS_DEF];
    logic [COLS_REG_W-1:0] cols_reg;
    logic [ROWS_REG_W-1:0] rows_reg;

    t_out_word expected_words [$];
    int        mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    // Out-of-range register values clamp to 1 at the bottom and the grid size at the top
    function automatic int area_cols();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
        return int'(cols_reg);
    endfunction

    function automatic int area_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
        return int'(rows_reg);
    endfunction

    function automatic bit in_area(int x, int y);
        return x < area_cols() && y < area_rows();
    endfunction

    function automatic logic [CELL_W-1:0] cell_type_at(int x, int y);
        if (!in_area(x, y)) return CELL_OPEN;
        return cell_grid[y][x];
    endfunction

    function automatic bit passable(int x, int y);
        return in_area(x, y) && cell_type_at(x, y) != CELL_WALL;
    endfunction

    // Work out the result of one command word and apply its effect on the grid
    function automatic t_out_word apply_command(t_in_word w);
        t_out_word         r;
        int                px;
        int                py;
        int                cols;
        int                rows;
        int                d;
        int                best;
        logic [COST_W:0]   sum;
        px   = int'(w.pos_x);
        py   = int'(w.pos_y);
        cols = area_cols();
        rows = area_rows();
        best = 0;
        r    = '0;
        r.cell_type_out = cell_type_at(px, py);
        case (w.command)
            CMD_WRITE: begin
                if (in_area(px, py)) cell_grid[py][px] = w.cell_type_in;
            end
            CMD_PICKUP: begin
                if (in_area(px, py) && r.cell_type_out == CELL_TARGET)
                    cell_grid[py][px] = CELL_OPEN;
            end
            CMD_NBR: begin
                sum = {1'b0, w.path_cost} + {1'b0, STEP_COST};
                r.neighbour_cost = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
                if (in_area(px, py)) begin
                    r.neighbour_mask[0] = (py > 0) && passable(px, py - 1);
                    r.neighbour_mask[1] = (px > 0) && passable(px - 1, py);
                    r.neighbour_mask[2] = passable(px + 1, py);
                    r.neighbour_mask[3] = passable(px, py + 1);
                end
            end
            CMD_NEAREST: begin
                // Keep the first target in row-major order on equal distance
                for (int y = 0; y < rows; y++) begin
                    for (int x = 0; x < cols; x++) begin
                        if (cell_grid[y][x] == CELL_TARGET) begin
                            d = (px > x ? px - x : x - px) + (py > y ? py - y : y - py);
                            if (!r.found || d < best) begin
                                r.found    = 1'b1;
                                best       = d;
                                r.result_x = POS_X_W'(x);
                                r.result_y = POS_Y_W'(y);
                            end
                        end
                    end
                end
                r.distance = DIST_W'(best);
            end
            CMD_HOME: begin
                for (int y = 0; y < rows; y++) begin
                    for (int x = 0; x < cols; x++) begin
                        if (!r.found && cell_grid[y][x] == CELL_HOME) begin
                            r.found    = 1'b1;
                            r.result_x = POS_X_W'(x);
                            r.result_y = POS_Y_W'(y);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Track configuration, check result words, queue predictions
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (int y = 0; y < MAX_ROWS_DEF; y++)
                for (int x = 0; x < MAX_COLS_DEF; x++)
                    cell_grid[y][x] = CELL_OPEN;
            cols_reg = COLS_RESET;
            rows_reg = ROWS_RESET;
            expected_words.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_COLS) cols_reg = i_cfg_data;
                else if (i_cfg_index == REG_ROWS) rows_reg = i_cfg_data[ROWS_REG_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_LIMIT)
                        $display("%0t: result word with nothing expected", $realtime);
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_data.cell_type_out  !== want.cell_type_out  ||
                        i_out_data.neighbour_mask !== want.neighbour_mask ||
                        i_out_data.neighbour_cost !== want.neighbour_cost ||
                        i_out_data.found          !== want.found          ||
                        i_out_data.result_x       !== want.result_x       ||
                        i_out_data.result_y       !== want.result_y       ||
                        i_out_data.distance       !== want.distance) begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_LIMIT) begin
                            $display("%0t: mismatch exp type %0d mask %h cost %0d found %0d (%0d,%0d) dist %0d",
                                     $realtime, want.cell_type_out, want.neighbour_mask,
                                     want.neighbour_cost, want.found, want.result_x,
                                     want.result_y, want.distance);
                            $display("%0t:          got type %0d mask %h cost %0d found %0d (%0d,%0d) dist %0d",
                                     $realtime, i_out_data.cell_type_out,
                                     i_out_data.neighbour_mask, i_out_data.neighbour_cost,
                                     i_out_data.found, i_out_data.result_x,
                                     i_out_data.result_y, i_out_data.distance);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(apply_command(i_in_data));
        end
        o_pending = expected_words.size();
    end

endmodule

/* tb/sv/tb_grid_map_nearest_target_search.sv */
// Testbench top for the grid map block: clock, reset, stimulus, stall control and verdict.
`timescale 1ns / 1ps

module tb_grid_map_nearest_target_search;
    import gmnt_pkg::*;

    localparam int IDLE_MAX    = 11;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 20;
    localparam int N_PHASES    = 9;

    // Command codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_word              in_word   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_word             out_word;
    int                    fail_count;
    int                    pending;
    int                    idle_max     = IDLE_MAX;
    bit                    hold_off_req = 1'b0;

    // Area settings per random phase, extremes and out-of-range values among them
    int phase_cols  [N_PHASES] = '{8, 0, 127, 5, 64, 1, 16, 33, 2};
    int phase_rows  [N_PHASES] = '{4, 0, 63, 3, 1, 32, 8, 17, 2};
    int phase_items [N_PHASES] = '{40, 15, 25, 40, 30, 30, 40, 30, 25};

    always #2 clk = ~clk;

    grid_map_nearest_target_search dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_word)
    );

    gmnt_result_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_word make_word(logic [CMD_W-1:0] cmd, int x, int y,
                                           logic [CELL_W-1:0] cell_kind, int cost);
        t_in_word w;
        w.command      = cmd;
        w.pos_x        = POS_X_W'(x);
        w.pos_y        = POS_Y_W'(y);
        w.cell_type_in = cell_kind;
        w.path_cost    = COST_W'(cost);
        return w;
    endfunction

    // Mostly in-area commands with plenty of writes to populate the grid
    function automatic t_in_word random_word(int cols, int rows);
        t_in_word w;
        int       pick;
        w.cell_type_in = CELL_W'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0) w.path_cost = COST_W'(16'hFFF0 + $urandom_range(0, 15));
        else w.path_cost = COST_W'($urandom);
        if ($urandom_range(0, 4) != 0) begin
            w.pos_x = POS_X_W'($urandom_range(0, cols - 1));
            w.pos_y = POS_Y_W'($urandom_range(0, rows - 1));
        end else begin
            w.pos_x = POS_X_W'($urandom);
            w.pos_y = POS_Y_W'($urandom);
        end
        pick = $urandom_range(0, 99);
        if (pick < 40)      w.command = CMD_WRITE;
        else if (pick < 50) w.command = CMD_PICKUP;
        else if (pick < 60) w.command = CMD_READ;
        else if (pick < 75) w.command = CMD_NBR;
        else if (pick < 86) w.command = CMD_NEAREST;
        else if (pick < 96) w.command = CMD_HOME;
        else if (pick < 98) w.command = CMD_SPARE_LO;
        else                w.command = CMD_SPARE_HI;
        return w;
    endfunction

    function automatic int clamp_area(int v, int max_v);
        if (v == 0) return 1;
        if (v > max_v) return max_v;
        return v;
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input t_in_word w);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_area(input int cols, input int rows);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_COLS;
        cfg_data  <= CFG_DATA_W'(cols);
        @(posedge clk);
        cfg_index <= REG_ROWS;
        cfg_data  <= CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: random stall per word, one long hold-off on request
    initial begin : receiver
        int n;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                n = HOLD_CYCLES;
            end else begin
                n = $urandom_range(0, idle_max);
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : stimulus
        int area_w;
        int area_h;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Full grid at reset size: corners, saturation, ties, empty scans, spare codes
        send_word(make_word(CMD_READ,     0,  0, CELL_OPEN,   0));
        send_word(make_word(CMD_WRITE,   63, 31, CELL_TARGET, 16'hFFFF));
        send_word(make_word(CMD_WRITE,    0,  0, CELL_HOME,   0));
        send_word(make_word(CMD_WRITE,    1,  0, CELL_WALL,   0));
        send_word(make_word(CMD_NEAREST,  0,  0, CELL_OPEN,   0));
        send_word(make_word(CMD_HOME,    63, 31, CELL_OPEN,   0));
        send_word(make_word(CMD_NBR,      0,  0, CELL_OPEN,   16'hFFFF));
        send_word(make_word(CMD_NBR,     63, 31, CELL_OPEN,   16'hFFFA));
        send_word(make_word(CMD_PICKUP,  63, 31, CELL_OPEN,   0));
        send_word(make_word(CMD_PICKUP,   0,  0, CELL_OPEN,   0));
        send_word(make_word(CMD_NEAREST,  0,  0, CELL_OPEN,   0));
        send_word(make_word(CMD_WRITE,   10, 10, CELL_TARGET, 0));
        send_word(make_word(CMD_WRITE,   12, 10, CELL_TARGET, 0));
        send_word(make_word(CMD_NEAREST, 11, 10, CELL_OPEN,   0));
        send_word(make_word(CMD_WRITE,   20,  3, CELL_TARGET, 0));
        send_word(make_word(CMD_NEAREST, 63,  0, CELL_OPEN,   0));
        send_word(make_word(CMD_SPARE_LO, 0,  0, CELL_TARGET, 16'hFFFF));
        send_word(make_word(CMD_SPARE_HI, 1,  0, CELL_TARGET, 16'hFFFF));
        send_word(make_word(CMD_WRITE,    0,  0, CELL_OPEN,   0));
        send_word(make_word(CMD_HOME,     0,  0, CELL_OPEN,   0));
        send_word(make_word(CMD_READ,     1,  0, CELL_OPEN,   0));

        // Small area: out-of-area writes ignored, stored targets outside not scanned
        wait_idle();
        set_area(3, 2);
        send_word(make_word(CMD_WRITE,    5,  5, CELL_HOME,   0));
        send_word(make_word(CMD_PICKUP,  10, 10, CELL_OPEN,   0));
        send_word(make_word(CMD_NBR,      2,  1, CELL_OPEN,   0));
        send_word(make_word(CMD_NBR,      3,  0, CELL_OPEN,   100));
        send_word(make_word(CMD_NEAREST, 40, 20, CELL_OPEN,   0));

        // Back to full size: hidden targets reappear
        wait_idle();
        set_area(64, 32);
        send_word(make_word(CMD_NEAREST,  0,  0, CELL_OPEN,   0));
        send_word(make_word(CMD_READ,     5,  5, CELL_OPEN,   0));

        // Random phases over several area settings
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            set_area(phase_cols[p], phase_rows[p]);
            area_w   = clamp_area(phase_cols[p], MAX_COLS_DEF);
            area_h   = clamp_area(phase_rows[p], MAX_ROWS_DEF);
            idle_max = (p % 3 == 2) ? 0 : IDLE_MAX;
            if (p == 3) hold_off_req = 1'b1;
            repeat (phase_items[p]) send_word(random_word(area_w, area_h));
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_grid_map_nearest_target_search: clean");
        end else begin
            $display("tb_grid_map_nearest_target_search: errors");
        end
        $finish;
    end

    // Bound the run well beyond the slowest legal schedule
    initial begin : watchdog
        #(12_000_000);
        $display("tb_grid_map_nearest_target_search: errors");
        $finish;
    end

endmodule
